/* sv/bmpg_pkg.sv */
// Shared types, codes and arithmetic helpers of the BMP row to grayscale unpacker.
package bmpg_pkg;

	// Default sizes
	localparam int MAX_WIDTH_DEF     = 2048;
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int QUEUE_DEPTH       = 4;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;

	// Pixel format codes
	localparam logic [2:0] FMT_1BPP  = 3'd0;
	localparam logic [2:0] FMT_2BPP  = 3'd1;
	localparam logic [2:0] FMT_8BPP  = 3'd2;
	localparam logic [2:0] FMT_24BPP = 3'd3;
	localparam logic [2:0] FMT_32BPP = 3'd4;

	// Input function codes
	localparam logic FUNC_RAW     = 1'b0;
	localparam logic FUNC_PAL_WR  = 1'b1;

	// Job kinds carried from front to back
	localparam logic [1:0] JOB_IDX  = 2'd0;
	localparam logic [1:0] JOB_GRAY = 2'd1;
	localparam logic [1:0] JOB_PAL  = 2'd2;

	// Index packing of a JOB_IDX job
	localparam logic [1:0] BPP_1 = 2'd0;
	localparam logic [1:0] BPP_2 = 2'd1;
	localparam logic [1:0] BPP_8 = 2'd2;

	// Luma weights
	localparam logic [17:0] W_RED   = 18'd77;
	localparam logic [17:0] W_GREEN = 18'd150;
	localparam logic [17:0] W_BLUE  = 18'd29;

	typedef struct packed {
		logic [1:0]  kind;     // JOB_IDX, JOB_GRAY or JOB_PAL
		logic [7:0]  val;      // raw byte, direct gray or palette luma
		logic [7:0]  idx;      // palette entry of a write
		logic [1:0]  bpp;      // index packing of a raw byte
		logic [3:0]  cnt;      // pixels to emit, 1 to 8
		logic [10:0] x0;       // column of the first pixel
		logic        row_end;  // final pixel of the job closes the row
	} bmpg_job_t;

	function automatic logic [7:0] luma(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		logic [17:0] s;
		s = 18'(r) * W_RED + 18'(g) * W_GREEN + 18'(b) * W_BLUE;
		return s[15:8];
	endfunction

endpackage

/* sv/bmpg_queue.sv */
// Small first-in first-out queue of jobs between front and back.
module bmpg_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* sv/bmpg_front.sv */
// Front end: takes input beats and register writes, tracks the row and queues jobs.
module bmpg_front
	import bmpg_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [11:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       func,
	input  logic [7:0] data_byte,
	input  logic [7:0] palette_index,
	input  logic [7:0] palette_red,
	input  logic [7:0] palette_green,
	input  logic [7:0] palette_blue,
	output logic       q_valid,
	input  logic       q_ready,
	output bmpg_job_t  q_job
);

	localparam int NPW = $clog2(MAX_WIDTH + 1);
	localparam int SW  = NPW + 6;
	localparam int CW  = (SW > 14) ? SW : 14;

	logic [2:0]     fmt_q;
	logic [11:0]    width_q;
	logic [12:0]    pos_q;
	logic [NPW-1:0] np_q;
	logic [1:0]     phase_q;
	logic [7:0]     blue_q, green_q;

	logic [31:0]    w32;
	logic [NPW-1:0] w_eff, rem;
	logic [CW-1:0]  w_c, wb_c, stride_c, pos_inc_c;
	logic           active, fmt_ok, is_rgb, restart, in_acc, cfg_acc, raw_acc;
	logic [3:0]     ppb;
	logic [1:0]     phase_nxt;

	assign in_ready = q_ready;
	assign in_acc   = in_valid && in_ready;
	assign cfg_acc  = cfg_valid;
	assign fmt_ok   = (fmt_q <= FMT_32BPP);
	assign is_rgb   = (fmt_q == FMT_24BPP) || (fmt_q == FMT_32BPP);
	assign raw_acc  = in_acc && (func == FUNC_RAW) && fmt_ok;

	// Clamp the width and derive the padded stride
	always_comb begin
		if (width_q == 12'd0) begin
			w32 = 32'd1;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w32 = 32'(MAX_WIDTH);
		end else begin
			w32 = 32'(width_q);
		end
		w_eff = w32[NPW-1:0];
		w_c   = CW'(w_eff);
		case (fmt_q)
			FMT_1BPP:  wb_c = w_c;
			FMT_2BPP:  wb_c = w_c << 1;
			FMT_8BPP:  wb_c = w_c << 3;
			FMT_24BPP: wb_c = (w_c << 4) + (w_c << 3);
			default:   wb_c = w_c << 5;
		endcase
		stride_c  = ((wb_c + CW'(31)) >> 5) << 2;
		pos_inc_c = CW'(pos_q) + CW'(1);
		restart   = (pos_inc_c >= stride_c);
	end

	assign active = (np_q < w_eff);
	assign rem    = w_eff - np_q;

	always_comb begin
		case (fmt_q)
			FMT_1BPP: ppb = 4'd8;
			FMT_2BPP: ppb = 4'd4;
			default:  ppb = 4'd1;
		endcase
		if ((fmt_q == FMT_24BPP) && (phase_q == 2'd2)) begin
			phase_nxt = 2'd0;
		end else begin
			phase_nxt = phase_q + 2'd1;
		end
	end

	// Classify the beat into a job
	always_comb begin
		q_job   = '0;
		q_valid = 1'b0;
		if (func == FUNC_PAL_WR) begin
			q_job.kind = JOB_PAL;
			q_job.idx  = palette_index;
			q_job.val  = luma(palette_red, palette_green, palette_blue);
			q_job.cnt  = 4'd1;
			q_valid    = in_valid;
		end else if (fmt_ok && active) begin
			q_job.x0 = 11'(np_q);
			if (is_rgb) begin
				q_job.kind    = JOB_GRAY;
				q_job.val     = luma(data_byte, green_q, blue_q);
				q_job.cnt     = 4'd1;
				q_job.row_end = ((np_q + NPW'(1)) == w_eff);
				q_valid       = in_valid && (phase_q == 2'd2);
			end else begin
				q_job.kind    = JOB_IDX;
				q_job.val     = data_byte;
				q_job.bpp     = fmt_q[1:0];
				q_job.cnt     = (rem < NPW'(ppb)) ? 4'(rem) : ppb;
				q_job.row_end = ((np_q + NPW'(q_job.cnt)) == w_eff);
				q_valid       = in_valid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_1BPP;
			width_q <= 12'd1;
			pos_q   <= '0;
			np_q    <= '0;
			phase_q <= '0;
			blue_q  <= '0;
			green_q <= '0;
		end else if (cfg_acc) begin
			if (cfg_index == REG_PIXEL_FORMAT) begin
				fmt_q   <= cfg_data[2:0];
				pos_q   <= '0;
				np_q    <= '0;
				phase_q <= '0;
			end else if (cfg_index == REG_IMAGE_WIDTH) begin
				width_q <= cfg_data;
				pos_q   <= '0;
				np_q    <= '0;
				phase_q <= '0;
			end
		end else if (raw_acc) begin
			if (is_rgb && active) begin
				if (phase_q == 2'd0) begin
					blue_q <= data_byte;
				end
				if (phase_q == 2'd1) begin
					green_q <= data_byte;
				end
			end
			if (restart) begin
				pos_q   <= '0;
				np_q    <= '0;
				phase_q <= '0;
			end else begin
				pos_q <= pos_inc_c[12:0];
				if (q_valid) begin
					np_q <= np_q + NPW'(q_job.cnt);
				end
				if (is_rgb && active) begin
					phase_q <= phase_nxt;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_np_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		np_q <= w_eff) else $error("pixel counter ran past the row width");
	a_pos_in_stride: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(pos_q) < stride_c) else $error("byte position outside the row stride");
	a_phase_24: assert property (@(posedge clk) disable iff (!arst_n)
		(fmt_q == FMT_24BPP) |-> (phase_q != 2'd3))
		else $error("alpha phase reached in 24 bpp");
`endif

endmodule

/* sv/bmpg_back.sv */
// Back end: expands queued jobs into pixels, owns the luma palette and the output register.
module bmpg_back
	import bmpg_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  bmpg_job_t   job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  gray,
	output logic [10:0] pixel_x,
	output logic        row_end,
	output logic        burst_last
);

	localparam int PIW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	// Expander
	logic        cur_vld_q;
	bmpg_job_t   cur_q;
	logic [7:0]  sh_q;
	logic [3:0]  k_q;
	logic [10:0] x_q;
	logic        last, load;

	// Request stage
	logic        vld_s1, wr_s1, direct_s1, re_s1, bl_s1;
	logic [7:0]  gray_s1, idx_s1;
	logic [10:0] x_s1;

	// Output stage
	logic        vld_s2, direct_s2, oob_s2, re_s2, bl_s2, pv_s2;
	logic [7:0]  gray_s2, idx_s2, rd_s2;
	logic [10:0] x_s2;

	logic [7:0]  pal_mem [PALETTE_DEPTH];
	logic [PALETTE_DEPTH-1:0] pal_vld_q;

	logic        adv_s1, adv_s2, oob_s1;
	logic [PIW-1:0] addr_s1;
	logic [7:0]  req_idx;

	assign adv_s2    = !vld_s2 || out_ready;
	assign adv_s1    = !vld_s1 || adv_s2;
	assign last      = (k_q == (cur_q.cnt - 4'd1));
	assign load      = !cur_vld_q || (adv_s1 && last);
	assign job_ready = load;
	assign addr_s1   = idx_s1[PIW-1:0];
	assign oob_s1    = (32'(idx_s1) >= 32'(PALETTE_DEPTH));

	always_comb begin
		case (cur_q.bpp)
			BPP_1:   req_idx = {7'd0, sh_q[7]};
			BPP_2:   req_idx = {6'd0, sh_q[7:6]};
			default: req_idx = sh_q;
		endcase
		if (cur_q.kind == JOB_PAL) begin
			req_idx = cur_q.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			pal_vld_q <= '0;
		end else begin
			if (load) begin
				cur_vld_q <= job_valid;
			end
			if (adv_s1) begin
				vld_s1 <= cur_vld_q;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1 && !wr_s1;
				// Palette write lands only once every older lookup has read
				if (vld_s1 && wr_s1 && !oob_s1) begin
					pal_vld_q[addr_s1] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= job;
			sh_q  <= job.val;
			k_q   <= 4'd0;
			x_q   <= job.x0;
		end else if (adv_s1) begin
			k_q <= k_q + 4'd1;
			x_q <= x_q + 11'd1;
			case (cur_q.bpp)
				BPP_1:   sh_q <= sh_q << 1;
				BPP_2:   sh_q <= sh_q << 2;
				default: sh_q <= sh_q;
			endcase
		end
		if (adv_s1) begin
			wr_s1     <= (cur_q.kind == JOB_PAL);
			direct_s1 <= (cur_q.kind == JOB_GRAY);
			gray_s1   <= cur_q.val;
			idx_s1    <= req_idx;
			x_s1      <= x_q;
			re_s1     <= cur_q.row_end && last;
			bl_s1     <= last;
		end
		if (adv_s2) begin
			rd_s2     <= pal_mem[addr_s1];
			pv_s2     <= pal_vld_q[addr_s1];
			oob_s2    <= oob_s1;
			direct_s2 <= direct_s1;
			gray_s2   <= gray_s1;
			idx_s2    <= idx_s1;
			x_s2      <= x_s1;
			re_s2     <= re_s1;
			bl_s2     <= bl_s1;
			if (vld_s1 && wr_s1 && !oob_s1) begin
				pal_mem[addr_s1] <= gray_s1;
			end
		end
	end

	assign out_valid  = vld_s2;
	assign pixel_x    = x_s2;
	assign row_end    = re_s2;
	assign burst_last = bl_s2;

	// Unwritten entries read as the identity ramp
	always_comb begin
		if (direct_s2) begin
			gray = gray_s2;
		end else if (oob_s2) begin
			gray = 8'd0;
		end else if (pv_s2) begin
			gray = rd_s2;
		end else begin
			gray = idx_s2;
		end
	end

`ifndef SYNTHESIS
	a_row_end_closes_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && row_end) |-> burst_last)
		else $error("row end on a pixel that is not last of its byte");
	a_job_count: assert property (@(posedge clk) disable iff (!arst_n)
		cur_vld_q |-> ((cur_q.cnt != 4'd0) && (cur_q.cnt <= 4'd8) && (k_q < cur_q.cnt)))
		else $error("expander count out of range");
	a_pal_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_vld_q && (cur_q.kind == JOB_PAL)) |-> (cur_q.cnt == 4'd1))
		else $error("palette write job spans more than one slot");
`endif

endmodule

/* sv/bmp_row_to_grayscale_top.sv */
// Top level of the BMP row to grayscale unpacker: front end, job queue and back end.
//
// Raw bytes of a stored BMP row enter one beat per cycle on the input channel, padding
// included; the block returns one 8-bit gray beat per pixel with its column, a row-end
// flag on the last pixel of the row and a burst-last flag on the last pixel a byte gave.
// At 1, 2 and 8 bpp the byte is split MSB first into palette indices and looked up in
// a luma palette that resets to the identity ramp; at 24 and 32 bpp the B, G, R bytes
// are weighted 29/150/77 and shifted down by 8, alpha is dropped. A palette-write beat
// stores the luma of its RGB entry and gives no pixel. Padding bytes up to the 4-byte
// stride give no pixel; after the last stride byte a new row begins, as it does after
// a pixel-format or image-width write. Rate: the back end delivers one pixel per cycle
// while out_ready is high; a byte yields up to 8 pixels at 1 bpp, up to 4 at 2 bpp and
// at most 1 otherwise; the front end takes a beat every cycle while the four-entry job
// queue has room. The first pixel of a byte passes the job queue, the expander register,
// the request stage and the output stage before it is valid. The configuration port
// never stalls; the user must write it only while the block is idle, since the block
// itself does not enforce this.
module bmp_row_to_grayscale_top
	import bmpg_pkg::*;
#(
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  palette_red,
	input  logic [7:0]  palette_green,
	input  logic [7:0]  palette_blue,
	// Result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  gray,
	output logic [10:0] pixel_x,
	output logic        row_end,
	output logic        burst_last
);

	localparam int JW = $bits(bmpg_job_t);

	logic      push_valid, push_ready, pop_valid, pop_ready;
	bmpg_job_t push_job, pop_job;
	logic [JW-1:0] pop_bits;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	// Classify beats, track the row position, hold B and G of a colour pixel
	bmpg_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.data_byte    (data_byte),
		.palette_index(palette_index),
		.palette_red  (palette_red),
		.palette_green(palette_green),
		.palette_blue (palette_blue),
		.q_valid      (push_valid),
		.q_ready      (push_ready),
		.q_job        (push_job)
	);

	// Decouple byte intake from pixel delivery
	bmpg_queue #(
		.WIDTH(JW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_job),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_bits)
	);

	assign pop_job = bmpg_job_t'(pop_bits);

	// Expand jobs into pixels; palette writes go in order with the lookups
	bmpg_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (pop_valid),
		.job_ready (pop_ready),
		.job       (pop_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.gray      (gray),
		.pixel_x   (pixel_x),
		.row_end   (row_end),
		.burst_last(burst_last)
	);

endmodule

/* dv/bmpg_luma_checker.sv */
// Checker of the BMP row to grayscale unpacker: watches all channels and predicts pixel beats.
module bmpg_luma_checker
	import bmpg_pkg::*;
#(
	parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  palette_index,
	input  logic [7:0]  palette_red,
	input  logic [7:0]  palette_green,
	input  logic [7:0]  palette_blue,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  gray,
	input  logic [10:0] pixel_x,
	input  logic        row_end,
	input  logic        burst_last,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [7:0]  gray;
		logic [10:0] x;
		logic        row_end;
		logic        burst_last;
	} pixel_t;

	logic [7:0]  luma_pal [256];
	int unsigned byte_pos;
	int unsigned next_px;
	int unsigned phase;
	logic [7:0]  held_b;
	logic [7:0]  held_g;
	logic [2:0]  fmt;
	logic [11:0] width_reg;
	int          errs;
	pixel_t      burst [$];
	pixel_t      pixels_due [$];

	assign fail_count = errs;

	function automatic logic [7:0] weigh(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		int unsigned s;
		s = 77 * int'(r) + 150 * int'(g) + 29 * int'(b);
		return 8'(s >> 8);
	endfunction

	function automatic logic [7:0] lookup(input int unsigned idx);
		return (idx >= PALETTE_DEPTH) ? 8'd0 : luma_pal[idx];
	endfunction

	function automatic int unsigned bits_of(input logic [2:0] f);
		case (f)
			FMT_1BPP:  return 1;
			FMT_2BPP:  return 2;
			FMT_8BPP:  return 8;
			FMT_24BPP: return 24;
			default:   return 32;
		endcase
	endfunction

	task automatic restart_row();
		byte_pos = 0;
		next_px  = 0;
		phase    = 0;
	endtask

	task automatic emit(input logic [7:0] g, input int unsigned w);
		pixel_t p;
		if (next_px >= w) return;
		p.gray       = g;
		p.x          = 11'(next_px);
		p.row_end    = (next_px + 1 == w);
		p.burst_last = 1'b0;
		burst.push_back(p);
		next_px++;
	endtask

	// Work out the pixel beats one raw row byte gives and queue them in order.
	task automatic unpack_byte(input logic [7:0] b);
		int unsigned w;
		int unsigned stride;
		if (fmt > FMT_32BPP) return;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		stride = ((w * bits_of(fmt) + 31) / 32) * 4;
		case (fmt)
			FMT_1BPP: begin
				for (int k = 0; k < 8; k++)
					emit(lookup((b >> (7 - k)) & 8'h01), w);
			end
			FMT_2BPP: begin
				for (int k = 0; k < 4; k++)
					emit(lookup((b >> (6 - 2 * k)) & 8'h03), w);
			end
			FMT_8BPP: begin
				emit(lookup(b), w);
			end
			default: begin
				if (next_px < w) begin
					case (phase)
						0: held_b = b;
						1: held_g = b;
						2: emit(weigh(b, held_g, held_b), w);
						default: ;
					endcase
					phase++;
					if (phase >= ((fmt == FMT_24BPP) ? 3 : 4))
						phase = 0;
				end
			end
		endcase
		byte_pos++;
		if (byte_pos >= stride)
			restart_row();
		byte_pos &= 32'h1FFF;
		if (burst.size() > 0) begin
			burst[burst.size() - 1].burst_last = 1'b1;
			foreach (burst[i])
				pixels_due.push_back(burst[i]);
			burst.delete();
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_v,
		input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t p;
		if (!arst_n) begin
			for (int i = 0; i < 256; i++)
				luma_pal[i] = 8'(i);
			restart_row();
			held_b    = '0;
			held_g    = '0;
			fmt       = FMT_1BPP;
			width_reg = 12'd1;
			errs      = 0;
			burst.delete();
			pixels_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_PIXEL_FORMAT) begin
					fmt = cfg_data[2:0];
					restart_row();
				end else if (cfg_index == REG_IMAGE_WIDTH) begin
					width_reg = cfg_data;
					restart_row();
				end
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_PAL_WR) begin
					if (palette_index < PALETTE_DEPTH)
						luma_pal[palette_index] = weigh(palette_red, palette_green,
							palette_blue);
				end else begin
					unpack_byte(data_byte);
				end
			end
			if (out_valid && out_ready) begin
				if (pixels_due.size() == 0) begin
					$error("unexpected pixel: gray %0d, pixel_x %0d", gray, pixel_x);
					errs++;
				end else begin
					p = pixels_due.pop_front();
					check_field("gray", p.gray, gray);
					check_field("pixel_x", p.x, pixel_x);
					check_field("row_end", p.row_end, row_end);
					check_field("burst_last", p.burst_last, burst_last);
				end
			end
			pending <= pixels_due.size();
		end
	end

endmodule

/* dv/testbench.sv */
// Testbench top of the BMP row to grayscale unpacker: clock, reset, stimulus and verdict.
module testbench;
	import bmpg_pkg::*;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = REG_PIXEL_FORMAT;
	logic [11:0] cfg_data      = '0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic        func          = FUNC_RAW;
	logic [7:0]  data_byte     = '0;
	logic [7:0]  palette_index = '0;
	logic [7:0]  palette_red   = '0;
	logic [7:0]  palette_green = '0;
	logic [7:0]  palette_blue  = '0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [7:0]  gray;
	logic [10:0] pixel_x;
	logic        row_end;
	logic        burst_last;

	// High while neither side may idle
	logic        quiet         = 1'b0;
	int          fail_count;
	int          pending;
	int unsigned item_count;

	bmp_row_to_grayscale_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.data_byte     (data_byte),
		.palette_index (palette_index),
		.palette_red   (palette_red),
		.palette_green (palette_green),
		.palette_blue  (palette_blue),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.gray          (gray),
		.pixel_x       (pixel_x),
		.row_end       (row_end),
		.burst_last    (burst_last)
	);

	bmpg_luma_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.data_byte     (data_byte),
		.palette_index (palette_index),
		.palette_red   (palette_red),
		.palette_green (palette_green),
		.palette_blue  (palette_blue),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.gray          (gray),
		.pixel_x       (pixel_x),
		.row_end       (row_end),
		.burst_last    (burst_last),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop, far beyond the slowest correct run
	initial begin
		#(12 * 300000);
		$display("testbench: errors");
		$finish;
	end

	// Result side: stall with a chance of about one in ten, never while quiet is set
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= quiet || ($urandom_range(0, 99) >= 10);
	end

	// Present one input beat and hold it until it is taken. Valid stays high into the
	// next beat unless a random gap is drawn, so back-to-back beats see no bubble.
	task automatic send_beat(input logic f, input logic [7:0] d, input logic [7:0] pi,
		input logic [7:0] pr, input logic [7:0] pg, input logic [7:0] pb);
		if (!quiet && $urandom_range(0, 99) < 5) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= f;
		data_byte     <= d;
		palette_index <= pi;
		palette_red   <= pr;
		palette_green <= pg;
		palette_blue  <= pb;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Raw row byte; the palette fields carry noise the block must disregard
	task automatic raw_byte(input logic [7:0] d);
		send_beat(FUNC_RAW, d, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic pal_write(input logic [7:0] i, input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		send_beat(FUNC_PAL_WR, 8'($urandom), i, r, g, b);
	endtask

	// Drop valid, wait for every predicted pixel, then let trailing pixel-less beats clear
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (12) @(posedge clk);
	endtask

	// Write both registers back to back while the block is idle; this also restarts the row
	task automatic configure(input logic [2:0] f, input logic [11:0] w);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= REG_PIXEL_FORMAT;
		cfg_data  <= {9'($urandom), f};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [2:0]  fmt;
		logic [11:0] w;
		int unsigned budget;
		int unsigned n;
		int unsigned roll;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: 1 bpp, one pixel per row, identity palette. First byte gives
		// one pixel, the other three are stride padding.
		raw_byte(8'h80);
		raw_byte(8'h7F);
		raw_byte(8'h00);
		raw_byte(8'hFF);

		// Palette writes at the colour extremes
		pal_write(8'h00, 8'hFF, 8'hFF, 8'hFF);
		pal_write(8'h01, 8'hFF, 8'h00, 8'h00);
		pal_write(8'hFF, 8'h00, 8'h00, 8'h00);

		// A full byte of 1 bpp pixels, then 2 bpp indices 0 to 3
		configure(FMT_1BPP, 12'd8);
		raw_byte(8'hA5);
		configure(FMT_2BPP, 12'd4);
		raw_byte(8'h1B);

		// 8 bpp: three pixels and one padding byte
		configure(FMT_8BPP, 12'd3);
		raw_byte(8'h00);
		raw_byte(8'hFF);
		raw_byte(8'h7F);
		raw_byte(8'h80);

		// 24 bpp and 32 bpp single pixels, alpha last
		configure(FMT_24BPP, 12'd1);
		raw_byte(8'hFF);
		raw_byte(8'hFF);
		raw_byte(8'hFF);
		configure(FMT_32BPP, 12'd1);
		raw_byte(8'h10);
		raw_byte(8'h20);
		raw_byte(8'h30);
		raw_byte(8'hFF);

		// Unused format codes swallow raw bytes
		configure(3'(FMT_32BPP + 1), 12'd2);
		raw_byte(8'hAA);
		configure('1, 12'd2);
		raw_byte(8'h55);

		// Width zero acts as one; an oversized width acts as the maximum
		configure(FMT_8BPP, 12'd0);
		raw_byte(8'h01);
		raw_byte(8'h02);
		configure(FMT_32BPP, 12'hFFF);
		raw_byte(8'h40);
		raw_byte(8'h80);
		raw_byte(8'hC0);

		// Random phases: a fresh setting each time, then a continuous byte stream with
		// occasional palette writes. Phases may end mid-row, which exercises the restart.
		item_count = 0;
		while (item_count < 470) begin
			quiet <= (item_count >= 180) && (item_count < 300);
			roll = $urandom_range(0, 99);
			if (roll < 12)
				fmt = 3'($urandom_range(FMT_32BPP + 1, 7));
			else
				fmt = 3'($urandom_range(FMT_1BPP, FMT_32BPP));
			roll = $urandom_range(0, 99);
			if (roll < 60)
				w = 12'($urandom_range(1, 12));
			else if (roll < 85)
				w = 12'($urandom_range(13, 64));
			else begin
				case ($urandom_range(0, 4))
					0:       w = 12'd1;
					1:       w = 12'd2047;
					2:       w = 12'd2048;
					3:       w = 12'hFFF;
					default: w = 12'd0;
				endcase
			end
			configure(fmt, w);

			// Ignored format: a handful of beats, not counted as items
			if (fmt > FMT_32BPP) begin
				repeat (6) raw_byte(8'($urandom));
				continue;
			end

			budget = $urandom_range(15, 50);
			for (n = 0; n < budget; n++) begin
				if ($urandom_range(0, 99) < 8)
					pal_write(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
				else
					raw_byte(8'($urandom));
			end
			item_count += budget;
		end

		quiet <= 1'b0;
		drain();
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

/* bmp_row_to_grayscale_top.f */
sv/bmpg_pkg.sv
sv/bmpg_queue.sv
sv/bmpg_front.sv
sv/bmpg_back.sv
sv/bmp_row_to_grayscale_top.sv
dv/bmpg_luma_checker.sv
dv/testbench.sv
